/* rtl/ansq_pkg.sv */
// shared codes, types and reset values for the navigation mode sequencer
// no dependencies
`timescale 1ns / 1ps

package ansq_pkg;

  localparam logic [2:0] MODE_PILOT  = 3'd0;
  localparam logic [2:0] MODE_HOLD   = 3'd1;
  localparam logic [2:0] MODE_RTH    = 3'd2;
  localparam logic [2:0] MODE_ATHOME = 3'd3;
  localparam logic [2:0] MODE_DESC   = 3'd4;
  localparam logic [2:0] MODE_TOUCH  = 3'd5;

  localparam logic [1:0] LAND_COMMENCE = 2'd0;
  localparam logic [1:0] LAND_DESCENT  = 2'd1;
  localparam logic [1:0] LAND_STOPPED  = 2'd2;

  localparam logic [1:0] STEER_NONE = 2'd0;
  localparam logic [1:0] STEER_HOME = 2'd1;
  localparam logic [1:0] STEER_HOLD = 2'd2;

  localparam logic [1:0] ALT_REQ_NONE    = 2'd0;
  localparam logic [1:0] ALT_REQ_RTH     = 2'd1;
  localparam logic [1:0] ALT_REQ_DESCEND = 2'd2;

  localparam logic [1:0] FAIL_NONE    = 2'd0;
  localparam logic [1:0] FAIL_MONITOR = 2'd1;
  localparam logic [1:0] FAIL_LOST    = 2'd2;

  localparam logic [2:0] CFG_LAND_START   = 3'd0;
  localparam logic [2:0] CFG_TOUCHDOWN    = 3'd1;
  localparam logic [2:0] CFG_MIN_DESCENT  = 3'd2;
  localparam logic [2:0] CFG_LAND_BUCKET  = 3'd3;
  localparam logic [2:0] CFG_RTH_LAND_DLY = 3'd4;
  localparam logic [2:0] CFG_RTH_HOVER    = 3'd5;

  localparam logic [14:0] RST_LAND_START   = 15'd30;
  localparam logic [15:0] RST_TOUCHDOWN    = 16'd50;
  localparam logic [14:0] RST_MIN_DESCENT  = 15'd5;
  localparam logic [14:0] RST_LAND_BUCKET  = 15'd3000;
  localparam logic [31:0] RST_RTH_LAND_DLY = 32'd10000;
  localparam logic [31:0] RST_RTH_HOVER    = 32'd5000;

  localparam logic [14:0] DT_MAX = 15'd32767;

  typedef struct packed {
    logic [14:0]        land_start_altitude;
    logic signed [15:0] touchdown_altitude;
    logic [14:0]        min_descent_rate;
    logic [14:0]        land_bucket_ms;
    logic [31:0]        rth_land_delay_ms;
    logic [31:0]        rth_hover_ms;
  } cfg_t;

  typedef struct packed {
    logic               nav_active;
    logic               update_ready;
    logic               return_home;
    logic               waypoint_reached;
    logic               auto_descend;
    logic               attitude_hold;
    logic               failsafe_enabled;
    logic               sticks_frozen;
    logic               alt_control_enabled;
    logic signed [15:0] altitude;
    logic signed [15:0] climb_rate;
    logic [31:0]        now_ms;
  } item_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [1:0] landing_phase;
    logic [1:0] steer_target;
    logic       capture_hold;
    logic [1:0] altitude_request;
    logic       landed;
    logic       lost_model;
    logic [1:0] fail_status;
    logic       auto_land_request;
    logic       clear_nav_hold;
  } res_t;

  typedef struct packed {
    logic run;
    logic restart;
  } land_ctl_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic        landed;
    logic        deadline_load;
    logic [31:0] deadline;
  } land_stat_t;

endpackage

/* rtl/autonomous_nav_mode_sequencer.sv */
// Navigation mode sequencer, top level: one event word in, one command word out.
// Each accepted word is registered, evaluated against the mode, landing and failsafe
// state combinationally and the command word is registered on the output;
// a new word is taken every cycle while the output is not stalled.
// The user must write configuration registers (cfg_we/cfg_index/cfg_data) only while
// idle, which the block does not enforce; depends on ansq_pkg and ansq_mode
`timescale 1ns / 1ps

module autonomous_nav_mode_sequencer import ansq_pkg::*; (
  input  logic               clk,
  input  logic               rst,

  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic               nav_active,
  input  logic               update_ready,
  input  logic               return_home,
  input  logic               waypoint_reached,
  input  logic               auto_descend,
  input  logic               attitude_hold,
  input  logic               failsafe_enabled,
  input  logic               sticks_frozen,
  input  logic               alt_control_enabled,
  input  logic signed [15:0] altitude,
  input  logic signed [15:0] climb_rate,
  input  logic [31:0]        now_ms,

  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         mode,
  output logic [1:0]         landing_phase,
  output logic [1:0]         steer_target,
  output logic               capture_hold,
  output logic [1:0]         altitude_request,
  output logic               landed,
  output logic               lost_model,
  output logic [1:0]         fail_status,
  output logic               auto_land_request,
  output logic               clear_nav_hold
);

  cfg_t  cfg;
  item_t in_word;
  logic  in_full;
  logic  fire;
  res_t  res;
  res_t  out_word;

  assign fire = in_full & (~out_valid | ~out_stall);
  assign in_stall = in_full & ~fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.land_start_altitude <= RST_LAND_START;
      cfg.touchdown_altitude <= RST_TOUCHDOWN;
      cfg.min_descent_rate <= RST_MIN_DESCENT;
      cfg.land_bucket_ms <= RST_LAND_BUCKET;
      cfg.rth_land_delay_ms <= RST_RTH_LAND_DLY;
      cfg.rth_hover_ms <= RST_RTH_HOVER;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LAND_START:   cfg.land_start_altitude <= cfg_data[14:0];
        CFG_TOUCHDOWN:    cfg.touchdown_altitude <= cfg_data[15:0];
        CFG_MIN_DESCENT:  cfg.min_descent_rate <= cfg_data[14:0];
        CFG_LAND_BUCKET:  cfg.land_bucket_ms <= cfg_data[14:0];
        CFG_RTH_LAND_DLY: cfg.rth_land_delay_ms <= cfg_data;
        CFG_RTH_HOVER:    cfg.rth_hover_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_word.nav_active <= nav_active;
      in_word.update_ready <= update_ready;
      in_word.return_home <= return_home;
      in_word.waypoint_reached <= waypoint_reached;
      in_word.auto_descend <= auto_descend;
      in_word.attitude_hold <= attitude_hold;
      in_word.failsafe_enabled <= failsafe_enabled;
      in_word.sticks_frozen <= sticks_frozen;
      in_word.alt_control_enabled <= alt_control_enabled;
      in_word.altitude <= altitude;
      in_word.climb_rate <= climb_rate;
      in_word.now_ms <= now_ms;
    end
  end

  ansq_mode u_mode (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .cfg  (cfg),
    .item (in_word),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_word <= res;
    end
  end

  assign mode = out_word.mode;
  assign landing_phase = out_word.landing_phase;
  assign steer_target = out_word.steer_target;
  assign capture_hold = out_word.capture_hold;
  assign altitude_request = out_word.altitude_request;
  assign landed = out_word.landed;
  assign lost_model = out_word.lost_model;
  assign fail_status = out_word.fail_status;
  assign auto_land_request = out_word.auto_land_request;
  assign clear_nav_hold = out_word.clear_nav_hold;

endmodule

/* rtl/ansq_land.sv */
// landing sub-state machine with leaky-bucket stall detector
// depends on ansq_pkg
`timescale 1ns / 1ps

module ansq_land import ansq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  land_ctl_t          ctl,
  input  cfg_t               cfg,
  input  logic signed [15:0] altitude,
  input  logic signed [15:0] climb_rate,
  input  logic [31:0]        now_ms,
  output land_stat_t         stat
);

  logic [1:0]  landing_reg;
  logic [1:0]  landing_reg_next;
  logic [15:0] stall_bucket;
  logic [15:0] stall_bucket_next;
  logic [31:0] last_landing_ms;

  logic [31:0] elapsed;
  logic [14:0] dt;
  logic [16:0] abs_alt;
  logic [16:0] abs_roc;
  logic [16:0] drain;
  logic [17:0] refill;
  logic        slow;

  always_comb begin
    elapsed = now_ms - last_landing_ms;
    dt = (elapsed > 32'(DT_MAX)) ? DT_MAX : elapsed[14:0];
    abs_alt = altitude[15] ? (17'd0 - {altitude[15], altitude}) : {1'b0, altitude};
    abs_roc = climb_rate[15] ? (17'd0 - {climb_rate[15], climb_rate}) : {1'b0, climb_rate};
    slow = abs_roc < {2'b00, cfg.min_descent_rate};
    drain = {1'b0, stall_bucket} - {2'b00, dt};
    refill = {2'b00, stall_bucket} + {2'b00, dt, 1'b0};

    landing_reg_next = landing_reg;
    stall_bucket_next = stall_bucket;
    stat.landed = 1'b0;
    stat.deadline_load = 1'b0;

    case (landing_reg)
      LAND_COMMENCE: begin
        if (abs_alt < {2'b00, cfg.land_start_altitude}) begin
          stall_bucket_next = {1'b0, cfg.land_bucket_ms};
          landing_reg_next = LAND_DESCENT;
        end
      end
      LAND_DESCENT: begin
        stat.deadline_load = ctl.run;
        if (slow) begin
          stall_bucket_next = drain[16] ? 16'd0 : drain[15:0];
          if (stall_bucket_next == 16'd0) begin
            landing_reg_next = LAND_STOPPED;
          end
        end else if (refill < {3'b000, cfg.land_bucket_ms}) begin
          stall_bucket_next = refill[15:0];
        end else begin
          stall_bucket_next = {1'b0, cfg.land_bucket_ms};
        end
      end
      LAND_STOPPED: begin
        landing_reg_next = LAND_COMMENCE;
        stat.landed = ctl.run;
      end
      default: begin
        landing_reg_next = landing_reg;
      end
    endcase

    stat.deadline = now_ms + {16'd0, stall_bucket_next};

    if (ctl.restart) begin
      stat.phase = LAND_COMMENCE;
    end else if (ctl.run) begin
      stat.phase = landing_reg_next;
    end else begin
      stat.phase = landing_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      landing_reg <= LAND_COMMENCE;
      stall_bucket <= 16'd0;
      last_landing_ms <= 32'd0;
    end else begin
      landing_reg <= stat.phase;
      if (ctl.run) begin
        stall_bucket <= stall_bucket_next;
        last_landing_ms <= now_ms;
      end
    end
  end

endmodule

/* rtl/ansq_mode.sv */
// navigation mode and failsafe sequencing, holds mode, deadline and failsafe state
// depends on ansq_pkg and ansq_land
`timescale 1ns / 1ps

module ansq_mode import ansq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  fire,
  input  cfg_t  cfg,
  input  item_t item,
  output res_t  res
);

  logic [2:0]  mode_reg;
  logic [2:0]  mode_reg_next;
  logic [31:0] deadline_ms;
  logic [31:0] deadline_ms_next;
  logic        lost_model_reg;
  logic        lost_model_reg_next;
  logic [1:0]  fail_status_reg;
  logic [1:0]  fail_status_reg_next;

  land_ctl_t  land_ctl;
  land_stat_t land_stat;

  logic [1:0] fs_status;
  logic       fs_lost;

  ansq_land u_land (
    .clk        (clk),
    .rst        (rst),
    .ctl        (land_ctl),
    .cfg        (cfg),
    .altitude   (item.altitude),
    .climb_rate (item.climb_rate),
    .now_ms     (item.now_ms),
    .stat       (land_stat)
  );

  // failsafe decode and landing machine control
  always_comb begin
    fs_lost = item.failsafe_enabled & item.sticks_frozen;
    if (!item.failsafe_enabled) begin
      fs_status = FAIL_NONE;
    end else if (item.sticks_frozen) begin
      fs_status = FAIL_LOST;
    end else begin
      fs_status = FAIL_MONITOR;
    end

    land_ctl.run = 1'b0;
    land_ctl.restart = 1'b0;
    if (item.nav_active) begin
      if (item.update_ready && ((mode_reg == MODE_TOUCH) ||
                                ((mode_reg == MODE_DESC) && item.return_home))) begin
        land_ctl.run = fire;
      end
    end else if ((mode_reg != MODE_TOUCH) && (mode_reg != MODE_DESC) &&
                 (item.return_home || fs_lost)) begin
      land_ctl.restart = fire;
    end
  end

  always_comb begin
    mode_reg_next = mode_reg;
    deadline_ms_next = deadline_ms;
    lost_model_reg_next = lost_model_reg;
    fail_status_reg_next = fail_status_reg;
    res.steer_target = STEER_NONE;
    res.capture_hold = 1'b0;
    res.altitude_request = ALT_REQ_NONE;
    res.auto_land_request = 1'b0;
    res.clear_nav_hold = 1'b0;

    if (item.nav_active) begin
      lost_model_reg_next = 1'b0;
      if (item.update_ready) begin
        case (mode_reg)
          MODE_TOUCH: begin
            res.steer_target = STEER_HOME;
            res.altitude_request = ALT_REQ_DESCEND;
          end
          MODE_DESC: begin
            res.steer_target = STEER_HOME;
            if (item.return_home) begin
              if ($signed(item.altitude) < $signed(cfg.touchdown_altitude)) begin
                mode_reg_next = MODE_TOUCH;
              end
              res.altitude_request = ALT_REQ_DESCEND;
            end else begin
              res.capture_hold = 1'b1;
              mode_reg_next = MODE_HOLD;
            end
          end
          MODE_ATHOME: begin
            res.steer_target = STEER_HOME;
            if (item.return_home) begin
              if (item.waypoint_reached) begin
                if (item.auto_descend && (item.now_ms > deadline_ms)) begin
                  deadline_ms_next = item.now_ms + cfg.rth_land_delay_ms;
                  mode_reg_next = MODE_DESC;
                end
              end else begin
                mode_reg_next = MODE_RTH;
              end
            end else begin
              res.capture_hold = 1'b1;
              mode_reg_next = MODE_HOLD;
            end
          end
          MODE_RTH: begin
            res.steer_target = STEER_HOME;
            if (item.return_home) begin
              if (item.waypoint_reached) begin
                deadline_ms_next = item.now_ms + cfg.rth_hover_ms;
                res.altitude_request = ALT_REQ_RTH;
                mode_reg_next = MODE_ATHOME;
              end
            end else begin
              res.capture_hold = 1'b1;
              mode_reg_next = MODE_HOLD;
            end
          end
          MODE_PILOT, MODE_HOLD: begin
            if (item.return_home) begin
              res.altitude_request = ALT_REQ_RTH;
              mode_reg_next = MODE_RTH;
            end else begin
              if (!item.attitude_hold) begin
                res.capture_hold = 1'b1;
                mode_reg_next = MODE_HOLD;
              end
              res.steer_target = STEER_HOLD;
            end
          end
          default: begin
            mode_reg_next = mode_reg;
          end
        endcase
        if (land_stat.deadline_load) begin
          deadline_ms_next = land_stat.deadline;
        end
      end
    end else begin
      res.clear_nav_hold = 1'b1;
      if (mode_reg == MODE_TOUCH) begin
        mode_reg_next = mode_reg;
      end else if (mode_reg == MODE_DESC) begin
        // failsafe is only evaluated without a return-home request
        if (!item.return_home) begin
          fail_status_reg_next = fs_status;
        end
        if (item.return_home || fs_lost) begin
          res.auto_land_request = item.alt_control_enabled;
        end else begin
          mode_reg_next = MODE_PILOT;
        end
      end else begin
        fail_status_reg_next = fs_status;
        mode_reg_next = MODE_PILOT;
        if (item.return_home || fs_lost) begin
          lost_model_reg_next = fs_lost;
          mode_reg_next = MODE_DESC;
        end
      end
    end

    res.mode = mode_reg_next;
    res.landing_phase = land_stat.phase;
    res.landed = land_stat.landed;
    res.lost_model = lost_model_reg_next;
    res.fail_status = fail_status_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg <= MODE_HOLD;
      deadline_ms <= 32'd0;
      lost_model_reg <= 1'b0;
      fail_status_reg <= FAIL_NONE;
    end else if (fire) begin
      mode_reg <= mode_reg_next;
      deadline_ms <= deadline_ms_next;
      lost_model_reg <= lost_model_reg_next;
      fail_status_reg <= fail_status_reg_next;
    end
  end

endmodule

/* sim/testbench.sv */
// testbench for autonomous_nav_mode_sequencer: directed and random navigation event words
// checked field by field against an in-bench model of the mode, landing and failsafe logic
// depends on ansq_pkg and the sequencer rtl
`timescale 1ns / 1ps

module testbench;
  import ansq_pkg::*;

  localparam logic [8:0] F_NAV    = 9'h100;
  localparam logic [8:0] F_UPD    = 9'h080;
  localparam logic [8:0] F_RTH    = 9'h040;
  localparam logic [8:0] F_REACH  = 9'h020;
  localparam logic [8:0] F_AUTOD  = 9'h010;
  localparam logic [8:0] F_AHOLD  = 9'h008;
  localparam logic [8:0] F_FSEN   = 9'h004;
  localparam logic [8:0] F_FROZEN = 9'h002;
  localparam logic [8:0] F_ALTC   = 9'h001;

  localparam logic [2:0] CFG_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;
  localparam int REFILL_GAIN = 2;

  logic clk;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic nav_active, update_ready, return_home, waypoint_reached, auto_descend;
  logic attitude_hold, failsafe_enabled, sticks_frozen, alt_control_enabled;
  logic signed [15:0] altitude, climb_rate;
  logic [31:0] now_ms;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] mode;
  logic [1:0] landing_phase, steer_target, altitude_request, fail_status;
  logic capture_hold, landed, lost_model, auto_land_request, clear_nav_hold;

  autonomous_nav_mode_sequencer dut (.*);

  item_t drv_word = '0;
  assign nav_active          = drv_word.nav_active;
  assign update_ready        = drv_word.update_ready;
  assign return_home         = drv_word.return_home;
  assign waypoint_reached    = drv_word.waypoint_reached;
  assign auto_descend        = drv_word.auto_descend;
  assign attitude_hold       = drv_word.attitude_hold;
  assign failsafe_enabled    = drv_word.failsafe_enabled;
  assign sticks_frozen       = drv_word.sticks_frozen;
  assign alt_control_enabled = drv_word.alt_control_enabled;
  assign altitude            = drv_word.altitude;
  assign climb_rate          = drv_word.climb_rate;
  assign now_ms              = drv_word.now_ms;

  item_t nav_events[$];
  res_t pending_cmds[$];
  res_t want_cmd;
  int words_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int gap_left = 0;
  int stall_left = 0;
  int tx_calm = 0;
  int rx_calm = 0;
  logic [31:0] clock_ms = '0;

  // shadow of the block's state and settings
  cfg_t cfg_shadow;
  logic [2:0] mode_q;
  logic [1:0] land_q;
  logic [1:0] fail_q;
  logic lost_q;
  int bucket;
  logic [31:0] last_land_ms;
  logic [31:0] deadline_q;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic int idle_len(inout int calm);
    int p;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    p = $urandom_range(0, 99);
    if (p < 4) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // leaky-bucket landing detector, returns the touchdown flag
  function automatic logic land_advance(input logic signed [15:0] alt,
                                        input logic signed [15:0] roc,
                                        input logic [31:0] now);
    logic [31:0] el;
    int dt, full, mag, lvl;
    logic hit;
    hit = 1'b0;
    el = now - last_land_ms;
    dt = (el > 32'd32767) ? 32767 : int'(el);
    full = int'(cfg_shadow.land_bucket_ms);
    last_land_ms = now;
    case (land_q)
      LAND_COMMENCE: begin
        mag = (alt < 0) ? -int'(alt) : int'(alt);
        if (mag < int'(cfg_shadow.land_start_altitude)) begin
          bucket = full;
          land_q = LAND_DESCENT;
        end
      end
      LAND_DESCENT: begin
        mag = (roc < 0) ? -int'(roc) : int'(roc);
        if (mag < int'(cfg_shadow.min_descent_rate)) begin
          bucket = bucket - dt;
          if (bucket <= 0) begin
            bucket = 0;
            land_q = LAND_STOPPED;
          end
        end else begin
          lvl = bucket + REFILL_GAIN * dt;
          bucket = (lvl < full) ? lvl : full;
        end
        deadline_q = now + 32'(bucket);
      end
      LAND_STOPPED: begin
        land_q = LAND_COMMENCE;
        hit = 1'b1;
      end
      default: ;
    endcase
    return hit;
  endfunction

  function automatic res_t next_command(input item_t w);
    res_t r;
    logic fs_lost;
    logic [1:0] fs_code;
    r = '0;
    fs_lost = w.failsafe_enabled & w.sticks_frozen;
    fs_code = !w.failsafe_enabled ? FAIL_NONE : (w.sticks_frozen ? FAIL_LOST : FAIL_MONITOR);
    if (w.nav_active) begin
      lost_q = 1'b0;
      if (w.update_ready) begin
        case (mode_q)
          MODE_TOUCH: begin
            r.steer_target = STEER_HOME;
            r.altitude_request = ALT_REQ_DESCEND;
            r.landed = land_advance(w.altitude, w.climb_rate, w.now_ms);
          end
          MODE_DESC: begin
            r.steer_target = STEER_HOME;
            if (w.return_home) begin
              if ($signed(w.altitude) < $signed(cfg_shadow.touchdown_altitude))
                mode_q = MODE_TOUCH;
              r.altitude_request = ALT_REQ_DESCEND;
              r.landed = land_advance(w.altitude, w.climb_rate, w.now_ms);
            end else begin
              r.capture_hold = 1'b1;
              mode_q = MODE_HOLD;
            end
          end
          MODE_ATHOME: begin
            r.steer_target = STEER_HOME;
            if (w.return_home) begin
              if (w.waypoint_reached) begin
                if (w.auto_descend && w.now_ms > deadline_q) begin
                  deadline_q = w.now_ms + cfg_shadow.rth_land_delay_ms;
                  mode_q = MODE_DESC;
                end
              end else begin
                mode_q = MODE_RTH;
              end
            end else begin
              r.capture_hold = 1'b1;
              mode_q = MODE_HOLD;
            end
          end
          MODE_RTH: begin
            r.steer_target = STEER_HOME;
            if (w.return_home) begin
              if (w.waypoint_reached) begin
                deadline_q = w.now_ms + cfg_shadow.rth_hover_ms;
                r.altitude_request = ALT_REQ_RTH;
                mode_q = MODE_ATHOME;
              end
            end else begin
              r.capture_hold = 1'b1;
              mode_q = MODE_HOLD;
            end
          end
          MODE_PILOT, MODE_HOLD: begin
            if (w.return_home) begin
              r.altitude_request = ALT_REQ_RTH;
              mode_q = MODE_RTH;
            end else begin
              if (!w.attitude_hold) begin
                r.capture_hold = 1'b1;
                mode_q = MODE_HOLD;
              end
              r.steer_target = STEER_HOLD;
            end
          end
          default: ;
        endcase
      end
    end else begin
      r.clear_nav_hold = 1'b1;
      if (mode_q == MODE_DESC) begin
        if (!w.return_home) fail_q = fs_code;
        if (w.return_home || fs_lost) r.auto_land_request = w.alt_control_enabled;
        else mode_q = MODE_PILOT;
      end else if (mode_q != MODE_TOUCH) begin
        fail_q = fs_code;
        mode_q = MODE_PILOT;
        if (w.return_home || fs_lost) begin
          lost_q = fs_lost;
          land_q = LAND_COMMENCE;
          mode_q = MODE_DESC;
        end
      end
    end
    r.mode = mode_q;
    r.landing_phase = land_q;
    r.lost_model = lost_q;
    r.fail_status = fail_q;
    return r;
  endfunction

  // event word driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
      mode_q = MODE_HOLD;
      land_q = LAND_COMMENCE;
      fail_q = FAIL_NONE;
      lost_q = 1'b0;
      bucket = 0;
      last_land_ms = '0;
      deadline_q = '0;
    end else begin
      if (in_valid && !in_stall) pending_cmds.push_back(next_command(drv_word));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (nav_events.size() != 0) begin
          drv_word <= nav_events.pop_front();
          in_valid <= 1'b1;
          gap_left = idle_len(tx_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // command word monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_cmds.size() == 0) begin
          $error("command word with no event pending");
          mismatches++;
        end else begin
          want_cmd = pending_cmds.pop_front();
          check_field("mode", want_cmd.mode, mode);
          check_field("landing_phase", want_cmd.landing_phase, landing_phase);
          check_field("steer_target", want_cmd.steer_target, steer_target);
          check_field("capture_hold", want_cmd.capture_hold, capture_hold);
          check_field("altitude_request", want_cmd.altitude_request, altitude_request);
          check_field("landed", want_cmd.landed, landed);
          check_field("lost_model", want_cmd.lost_model, lost_model);
          check_field("fail_status", want_cmd.fail_status, fail_status);
          check_field("auto_land_request", want_cmd.auto_land_request, auto_land_request);
          check_field("clear_nav_hold", want_cmd.clear_nav_hold, clear_nav_hold);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = idle_len(rx_calm);
      end
    end
  end

  function automatic item_t nav_event(input logic [8:0] fl, input logic [15:0] alt,
                                      input logic [15:0] roc, input logic [31:0] now);
    item_t w;
    {w.nav_active, w.update_ready, w.return_home, w.waypoint_reached, w.auto_descend,
     w.attitude_hold, w.failsafe_enabled, w.sticks_frozen, w.alt_control_enabled} = fl;
    w.altitude = alt;
    w.climb_rate = roc;
    w.now_ms = now;
    return w;
  endfunction

  task automatic queue_event(input item_t w);
    nav_events.push_back(w);
    words_sent++;
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_LAND_START:   cfg_shadow.land_start_altitude = val[14:0];
      CFG_TOUCHDOWN:    cfg_shadow.touchdown_altitude = val[15:0];
      CFG_MIN_DESCENT:  cfg_shadow.min_descent_rate = val[14:0];
      CFG_LAND_BUCKET:  cfg_shadow.land_bucket_ms = val[14:0];
      CFG_RTH_LAND_DLY: cfg_shadow.rth_land_delay_ms = val;
      CFG_RTH_HOVER:    cfg_shadow.rth_hover_ms = val;
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [14:0] ls, input logic [15:0] td,
                               input logic [14:0] mr, input logic [14:0] bk,
                               input logic [31:0] dly, input logic [31:0] hov);
    cfg_write(CFG_LAND_START, {17'h0, ls});
    cfg_write(CFG_TOUCHDOWN, {16'h0, td});
    cfg_write(CFG_MIN_DESCENT, {17'h0, mr});
    cfg_write(CFG_LAND_BUCKET, {17'h0, bk});
    cfg_write(CFG_RTH_LAND_DLY, dly);
    cfg_write(CFG_RTH_HOVER, hov);
  endtask

  // wait for every command word, then let the pipeline drain
  task automatic settle();
    while (results_seen < words_sent) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [31:0] advance_clock(input int span);
    int p;
    p = $urandom_range(0, 99);
    if (p < 80) clock_ms += $urandom_range(0, span);
    else if (p < 96) clock_ms += $urandom_range(0, 40000);
    else clock_ms = $urandom;
    return clock_ms;
  endfunction

  function automatic logic [15:0] near_zero(input int lim);
    int mag;
    mag = $urandom_range(0, (lim > 32767) ? 32767 : lim);
    return ($urandom_range(0, 1) != 0) ? 16'(-mag) : 16'(mag);
  endfunction

  task automatic add_random(input int target);
    int added, kind, n, k;
    logic [8:0] fl;
    logic [15:0] alt, roc;
    logic [31:0] now;
    added = 0;
    while (added < target) begin
      kind = $urandom_range(0, 99);
      n = $urandom_range(4, 16);
      for (k = 0; k < n; k++) begin
        if (kind < 35) begin
          // landing run: drop into descent, then descend with home requested
          if (k == 0)
            fl = ($urandom_range(0, 3) == 0) ? (F_FSEN | F_FROZEN) : F_RTH;
          else if ($urandom_range(0, 11) == 0)
            fl = 9'($urandom);
          else
            fl = F_NAV | F_UPD | F_RTH | (9'($urandom) & (F_REACH | F_AUTOD | F_AHOLD | F_ALTC));
          alt = near_zero(int'(cfg_shadow.land_start_altitude) * 5 / 4 + 2);
          roc = near_zero(int'(cfg_shadow.min_descent_rate) * 2 + 2);
          now = advance_clock(int'(cfg_shadow.land_bucket_ms) / 3 + 10);
        end else if (kind < 60) begin
          // return home and hover
          fl = F_NAV | F_UPD | F_RTH | (9'($urandom) & (F_REACH | F_AHOLD | F_ALTC | F_FSEN));
          if ($urandom_range(0, 3) != 0) fl |= F_AUTOD;
          if ($urandom_range(0, 9) == 0) fl &= ~F_RTH;
          if ($urandom_range(0, 9) == 0) fl &= ~F_UPD;
          alt = 16'($urandom);
          roc = 16'($urandom);
          now = advance_clock(2000);
        end else if (kind < 75) begin
          // navigation dropping out
          if ($urandom_range(0, 2) == 0) fl = F_NAV | F_UPD | (9'($urandom) & ~F_NAV);
          else fl = 9'($urandom) & ~F_NAV;
          alt = 16'($urandom);
          roc = 16'($urandom);
          now = advance_clock(2000);
        end else begin
          fl = 9'($urandom);
          alt = 16'($urandom);
          roc = 16'($urandom);
          now = ($urandom_range(0, 3) == 0) ? $urandom : advance_clock(5000);
        end
        queue_event(nav_event(fl, alt, roc, now));
        added++;
      end
    end
  endtask

  initial begin
    logic [31:0] t;
    cfg_shadow = {RST_LAND_START, RST_TOUCHDOWN, RST_MIN_DESCENT, RST_LAND_BUCKET,
                  RST_RTH_LAND_DLY, RST_RTH_HOVER};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset settings: walk the mode machine and the inactive paths
    queue_event(nav_event(F_NAV, 16'h7FFF, 16'h8000, 32'd0));
    queue_event(nav_event(F_NAV | F_UPD | F_AHOLD, 16'h8000, 16'h7FFF, 32'd1));
    queue_event(nav_event(F_NAV | F_UPD, 16'd0, 16'd0, 32'd2));
    queue_event(nav_event(F_FSEN, 16'd0, 16'd0, 32'd3));
    queue_event(nav_event(F_NAV | F_UPD | F_AHOLD, 16'd5, 16'd5, 32'd4));
    queue_event(nav_event(F_NAV | F_UPD | F_RTH, 16'd500, 16'd0, 32'd10));
    queue_event(nav_event(F_NAV | F_UPD | F_RTH | F_REACH, 16'd500, 16'd0, 32'd100));
    queue_event(nav_event(F_NAV | F_UPD | F_RTH | F_REACH | F_AUTOD, 16'd500, 16'd0,
                          32'd5100));
    queue_event(nav_event(F_NAV | F_UPD | F_RTH, 16'd500, 16'd0, 32'd5200));
    queue_event(nav_event(F_NAV | F_UPD, 16'd500, 16'd0, 32'd5300));
    queue_event(nav_event(F_NAV | F_UPD | F_RTH, 16'd500, 16'd0, 32'd5400));
    queue_event(nav_event(F_NAV | F_UPD | F_RTH | F_REACH, 16'd500, 16'd0, 32'hFFFF_F000));
    queue_event(nav_event(F_NAV | F_UPD | F_RTH | F_REACH | F_AUTOD, 16'd500, 16'd0,
                          32'hFFFF_F001));
    queue_event(nav_event(F_NAV | F_UPD | F_RTH, 16'd100, 16'd0, 32'hFFFF_F010));
    queue_event(nav_event(F_NAV | F_UPD, 16'd100, 16'd0, 32'hFFFF_F020));
    queue_event(nav_event(F_RTH, 16'd0, 16'd0, 32'hFFFF_F030));
    queue_event(nav_event(F_RTH | F_ALTC, 16'd0, 16'd0, 32'hFFFF_F040));
    queue_event(nav_event(F_FSEN, 16'd0, 16'd0, 32'hFFFF_F050));
    queue_event(nav_event(F_FSEN | F_FROZEN | F_ALTC, 16'd0, 16'd0, 32'hFFFF_F060));
    queue_event(nav_event(F_FSEN | F_FROZEN | F_ALTC, 16'd0, 16'd0, 32'hFFFF_F070));
    settle();

    // touchdown out of reach: landing detector runs while descending
    cfg_write(CFG_SPARE_LO, $urandom);
    cfg_write(CFG_SPARE_HI, $urandom);
    load_settings(15'd200, 16'h8000, 15'd20, 15'd500, 32'd300, 32'd200);
    add_random(120);
    settle();

    load_settings(15'h7FFF, 16'h8000, 15'h7FFF, 15'd1, 32'hFFFF_FFFF, 32'd0);
    add_random(100);
    settle();

    load_settings(15'd0, 16'h8000, 15'd0, 15'h7FFF, 32'd0, 32'hFFFF_FFFF);
    add_random(100);
    settle();

    // touchdown reachable from here on, and it holds until reset
    load_settings(15'($urandom_range(20, 400)), 16'h7FFF, 15'($urandom_range(1, 60)),
                  15'($urandom_range(1, 4000)), $urandom, $urandom_range(0, 3000));
    t = clock_ms;
    queue_event(nav_event(F_RTH, 16'd0, 16'd0, t));
    queue_event(nav_event(F_NAV | F_UPD | F_RTH, 16'd0, 16'd0, t + 32'd10));
    queue_event(nav_event(F_NAV | F_UPD, 16'd0, 16'd0, t + 32'd20));
    queue_event(nav_event(F_FSEN | F_FROZEN, 16'd0, 16'd0, t + 32'd30));
    clock_ms = t + 32'd30;
    add_random(60);
    settle();

    if (pending_cmds.size() != 0) begin
      $error("%0d command words never arrived", pending_cmds.size());
      mismatches++;
    end
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
